/* src/bmmp_pkg.sv */
`timescale 1ns / 1ps

package bmmp_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 24;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int CC_W        = 4;
  localparam int FPB_W       = 16;
  localparam int BUCKET_W    = 32;
  localparam int CHIDX_W     = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES_PER_BUCKET = 1'd1;

  localparam logic [CC_W-1:0]  CC_RESET  = 4'd1;
  localparam logic [FPB_W-1:0] FPB_RESET = 16'd256;
  localparam logic [FPB_W-1:0] FPB_SAT   = 16'hFFFF;

  // snapshot request from the accumulator to the drain
  typedef struct packed {
    logic                load;
    logic [BUCKET_W-1:0] bucket;
  } snap_ctrl_t;

  typedef struct packed {
    logic busy;       // snapshot holds results not yet loaded to the output
    logic finishing;  // last result of the snapshot loads this cycle
  } drain_status_t;

endpackage

/* src/bmmp_drain.sv */
`timescale 1ns / 1ps

module bmmp_drain import bmmp_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  snap_ctrl_t                    ctrl,
  input  logic [CNT_W-1:0]              count,
  input  logic signed [SAMPLE_BITS-1:0] snap_min_in [MAX_CHANNELS],
  input  logic signed [SAMPLE_BITS-1:0] snap_max_in [MAX_CHANNELS],
  output drain_status_t                 status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CHIDX_W-1:0]            channel_index,
  output logic [BUCKET_W-1:0]           bucket_index,
  output logic signed [SAMPLE_BITS-1:0] bucket_min,
  output logic signed [SAMPLE_BITS-1:0] bucket_max,
  output logic                          last_of_run
);

  logic signed [SAMPLE_BITS-1:0] snap_min [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] snap_max [MAX_CHANNELS];
  logic [BUCKET_W-1:0]           snap_bucket;
  logic [CNT_W-1:0]              cnt;
  logic [CH_W-1:0]               idx;
  logic                          busy;
  logic                          out_load;
  logic                          idx_last;

  assign out_load = busy && (!out_valid || out_ready);
  assign idx_last = (32'(idx) + 32'd1) == 32'(cnt);

  assign status.busy      = busy;
  assign status.finishing = out_load && idx_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // a new snapshot may land in the cycle the old one finishes
      if (ctrl.load) begin
        busy <= 1'b1;
        idx  <= '0;
      end else begin
        if (out_load) begin
          idx <= idx + 1'b1;
        end
        if (out_load && idx_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      channel_index <= CHIDX_W'(idx);
      bucket_index  <= snap_bucket;
      bucket_min    <= snap_min[idx];
      bucket_max    <= snap_max[idx];
      last_of_run   <= idx_last;
    end
    if (ctrl.load) begin
      snap_min    <= snap_min_in;
      snap_max    <= snap_max_in;
      snap_bucket <= ctrl.bucket;
      cnt         <= count;
    end
  end

endmodule

/* src/bucket_min_max_peaks_core.sv */
`timescale 1ns / 1ps

// Min/max decimation of an interleaved sample stream. Samples enter one per
// cycle, channels in order 0 up to the effective channel count minus one, and
// update a per-channel running min and max in the same cycle. When a bucket
// closes (frames_per_bucket frames done, or end_of_stream on the last sample of
// a frame) the running values are copied into a snapshot and cleared, and the
// snapshot drains one result per cycle unless stalled, channel 0 first,
// last_of_run on the highest channel. Sustained input rate is one sample per
// cycle; a closing sample is held off only while the previous bucket's snapshot
// still has results not yet moved to the output register, so a bucket needs at
// least as many samples as there are channels to keep full rate.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
module bucket_min_max_peaks_core import bmmp_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          end_of_stream,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CHIDX_W-1:0]            channel_index,
  output logic [BUCKET_W-1:0]           bucket_index,
  output logic signed [SAMPLE_BITS-1:0] bucket_min,
  output logic signed [SAMPLE_BITS-1:0] bucket_max,
  output logic                          last_of_run
);

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [CC_W-1:0]     chan_count;
  logic [FPB_W-1:0]    frames_per_bucket;

  logic signed [SAMPLE_BITS-1:0] running_min [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] running_max [MAX_CHANNELS];
  logic [CH_W-1:0]     channel_position;
  logic [FPB_W-1:0]    frames_in_bucket;
  logic [BUCKET_W-1:0] bucket_counter;

  logic [31:0]         nch_wide;
  logic [CNT_W-1:0]    nch;
  logic [FPB_W-1:0]    fpb_eff;
  logic [FPB_W-1:0]    frames_next;
  logic                frame_done;
  logic                close_now;
  logic                accept;
  logic signed [SAMPLE_BITS-1:0] upd_min;
  logic signed [SAMPLE_BITS-1:0] upd_max;
  logic signed [SAMPLE_BITS-1:0] snap_min_in [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] snap_max_in [MAX_CHANNELS];
  snap_ctrl_t          ctrl;
  drain_status_t       status;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_count        <= CC_RESET;
      frames_per_bucket <= FPB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNEL_COUNT:     chan_count        <= cfg_data[CC_W-1:0];
        CFG_FRAMES_PER_BUCKET: frames_per_bucket <= cfg_data[FPB_W-1:0];
        default: ;
      endcase
    end
  end

  // effective channel count: zero acts as one, clamp to the channel capacity
  always_comb begin
    if (chan_count == '0) begin
      nch_wide = 32'd1;
    end else if (32'(chan_count) > 32'(MAX_CHANNELS)) begin
      nch_wide = 32'(MAX_CHANNELS);
    end else begin
      nch_wide = 32'(chan_count);
    end
  end
  assign nch     = nch_wide[CNT_W-1:0];
  assign fpb_eff = (frames_per_bucket == '0) ? FPB_RESET / FPB_RESET : frames_per_bucket;

  assign frame_done  = (32'(channel_position) + 32'd1) >= 32'(nch);
  assign frames_next = (frames_in_bucket < FPB_SAT) ? frames_in_bucket + 1'b1
                                                    : frames_in_bucket;
  assign close_now   = frame_done && ((frames_next >= fpb_eff) || end_of_stream);

  assign in_ready = !status.busy || status.finishing || !close_now;
  assign accept   = in_valid && in_ready;

  assign upd_min = (sample < running_min[channel_position]) ? sample
                                                            : running_min[channel_position];
  assign upd_max = (sample > running_max[channel_position]) ? sample
                                                            : running_max[channel_position];

  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (CH_W'(c) == channel_position) begin
        snap_min_in[c] = upd_min;
        snap_max_in[c] = upd_max;
      end else begin
        snap_min_in[c] = running_min[c];
        snap_max_in[c] = running_max[c];
      end
    end
  end

  assign ctrl.load   = accept && close_now;
  assign ctrl.bucket = bucket_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        running_min[c] <= SMP_MAX;
        running_max[c] <= SMP_MIN;
      end
      channel_position <= '0;
      frames_in_bucket <= '0;
      bucket_counter   <= '0;
    end else if (accept) begin
      if (close_now) begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          running_min[c] <= SMP_MAX;
          running_max[c] <= SMP_MIN;
        end
        frames_in_bucket <= '0;
        bucket_counter   <= bucket_counter + 1'b1;
      end else begin
        running_min[channel_position] <= upd_min;
        running_max[channel_position] <= upd_max;
        if (frame_done) begin
          frames_in_bucket <= frames_next;
        end
      end
      channel_position <= frame_done ? '0 : channel_position + 1'b1;
    end
  end

  bmmp_drain #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_drain (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .count         (nch),
    .snap_min_in   (snap_min_in),
    .snap_max_in   (snap_max_in),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .bucket_index  (bucket_index),
    .bucket_min    (bucket_min),
    .bucket_max    (bucket_max),
    .last_of_run   (last_of_run)
  );

  // a snapshot never overwrites results still waiting to be loaded
  a_no_snap_overrun: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |-> (!status.busy || status.finishing))
    else $error("snapshot overwritten while results pending");

  a_snap_starts_drain: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |=> status.busy)
    else $error("drain not busy after snapshot");

  a_bucket_advance: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |=> (bucket_counter == $past(bucket_counter) + 1'b1))
    else $error("bucket counter did not advance on close");

  a_drain_after_close: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |=> (out_valid || status.busy))
    else $error("closed bucket produced no pending result");

endmodule
